// ===== sv/riff_wave_chunk_parser_defines.svh =====
// Assertion macros for the RIFF/WAVE chunk parser; only rwcp_parse includes them.
`ifndef RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH
`define RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define RWCP_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define RWCP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rwcp_pkg.sv =====
// Types and constants shared by the RIFF/WAVE chunk parser modules.
`default_nettype none

package rwcp_pkg;

    // Little-endian chunk tags as they appear in an assembled word.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Byte position saturates at 40 bits.
    localparam logic [39:0] POS_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [15:0] MIN_FORMAT_LENGTH_RESET = 16'd14;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_LEN  = 3'd1,
        PH_FORM = 3'd2,
        PH_KIND = 3'd3,
        PH_CLEN = 3'd4,
        PH_SKIP = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_WAVE  = 3'd1,
        ST_NOT_RIFF  = 3'd2,
        ST_FMT_SHORT = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] format_offset;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t result;
    } emit_t;

endpackage

`default_nettype wire

// ===== sv/rwcp_in_stage.sv =====
// Input register that holds one accepted byte beat until the parser takes it.
`default_nettype none

module rwcp_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rwcp_pkg::beat_t in_beat,
    input  wire logic           take,
    output logic                held_valid,
    output rwcp_pkg::beat_t     held_beat
);
    import rwcp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    // Room for a new beat whenever the register is empty or the held one is consumed this cycle.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

endmodule

`default_nettype wire

// ===== sv/rwcp_parse.sv =====
// Per-byte RIFF/WAVE parse state and its next-state logic.
`default_nettype none
`include "riff_wave_chunk_parser_defines.svh"

module rwcp_parse (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_write_en,
    input  wire logic [15:0]     cfg_write_data,
    input  wire logic            go,
    input  wire rwcp_pkg::beat_t beat,
    output rwcp_pkg::emit_t      emit
);
    import rwcp_pkg::*;

    logic [15:0] min_len_reg;
    logic [39:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  fill_reg, fill_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] riff_reg, riff_next;
    logic [32:0] area_end_reg, area_end_next;
    logic [31:0] kind_reg, kind_next;
    logic [32:0] skip_reg, skip_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [31:0] fmt_start_reg, fmt_start_next;
    logic        data_seen_reg, data_seen_next;
    logic [31:0] data_start_reg, data_start_next;
    logic [31:0] data_len_reg, data_len_next;
    logic        finished_reg, finished_next;

    logic [31:0] word;
    logic [39:0] pos_inc;
    logic [32:0] skip_dec;
    logic [32:0] skip_len;
    logic        area_done;
    logic        data_taken;
    logic        emit_now;
    status_t     status_now;

    assign word       = {beat.file_byte, shift_reg[31:8]};
    assign pos_inc    = (pos_reg != POS_MAX) ? pos_reg + 40'd1 : pos_reg;
    assign area_done  = pos_inc >= {7'd0, area_end_reg};
    assign skip_dec   = (skip_reg != 33'd0) ? skip_reg - 33'd1 : skip_reg;
    assign skip_len   = ({1'b0, word} + 33'd1) & ~33'd1;
    assign data_taken = data_seen_reg && (data_len_reg != 32'd0);

    always_comb
    begin
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        fill_next       = fill_reg;
        phase_next      = phase_reg;
        riff_next       = riff_reg;
        area_end_next   = area_end_reg;
        kind_next       = kind_reg;
        skip_next       = skip_reg;
        fmt_seen_next   = fmt_seen_reg;
        fmt_start_next  = fmt_start_reg;
        data_seen_next  = data_seen_reg;
        data_start_next = data_start_reg;
        data_len_next   = data_len_reg;
        finished_next   = finished_reg;
        emit_now        = 1'b0;
        status_now      = ST_OK;

        if (go && !finished_reg)
        begin
            shift_next = word;
            pos_next   = pos_inc;
            if (phase_reg == PH_SKIP)
            begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0)
                begin
                    if (area_done)
                    begin
                        emit_now   = 1'b1;
                        status_now = ST_NOT_FOUND;
                    end
                    else
                    begin
                        phase_next = PH_KIND;
                    end
                end
            end
            else
            begin
                fill_next = fill_reg + 2'd1;
                if (fill_reg == 2'd3)
                begin
                    case (phase_reg)
                        PH_RIFF:
                        begin
                            riff_next  = word;
                            phase_next = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            area_end_next = 33'd8 + {1'b0, word};
                            phase_next    = PH_FORM;
                        end
                        PH_FORM:
                        begin
                            if (word != TAG_WAVE)
                            begin
                                emit_now   = 1'b1;
                                status_now = ST_NOT_WAVE;
                            end
                            else if (riff_reg != TAG_RIFF)
                            begin
                                emit_now   = 1'b1;
                                status_now = ST_NOT_RIFF;
                            end
                            else if (area_done)
                            begin
                                emit_now   = 1'b1;
                                status_now = ST_NOT_FOUND;
                            end
                            else
                            begin
                                phase_next = PH_KIND;
                            end
                        end
                        PH_KIND:
                        begin
                            kind_next  = word;
                            phase_next = PH_CLEN;
                        end
                        PH_CLEN:
                        begin
                            if (kind_reg == TAG_FMT && !fmt_seen_reg)
                            begin
                                if (word < {16'd0, min_len_reg})
                                begin
                                    emit_now   = 1'b1;
                                    status_now = ST_FMT_SHORT;
                                end
                                else
                                begin
                                    fmt_seen_next  = 1'b1;
                                    fmt_start_next = pos_inc[31:0];
                                    if (data_taken)
                                    begin
                                        emit_now   = 1'b1;
                                        status_now = ST_OK;
                                    end
                                end
                            end
                            else if (kind_reg == TAG_DATA && !data_taken)
                            begin
                                data_seen_next  = 1'b1;
                                data_start_next = pos_inc[31:0];
                                data_len_next   = word;
                                if (fmt_seen_reg)
                                begin
                                    emit_now   = 1'b1;
                                    status_now = ST_OK;
                                end
                            end
                            // Body skip, padded to an even length, unless a result ended the file.
                            if (!emit_now)
                            begin
                                skip_next = skip_len;
                                if (skip_len == 33'd0)
                                begin
                                    if (area_done)
                                    begin
                                        emit_now   = 1'b1;
                                        status_now = ST_NOT_FOUND;
                                    end
                                    else
                                    begin
                                        phase_next = PH_KIND;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            if (beat.last_byte && !emit_now)
            begin
                emit_now   = 1'b1;
                status_now = ST_NOT_FOUND;
            end
            if (emit_now)
            begin
                finished_next = 1'b1;
            end
        end

        emit.valid                = emit_now;
        emit.result.status        = status_now;
        emit.result.format_offset = fmt_start_next;
        emit.result.data_offset   = data_start_next;
        emit.result.data_size     = data_len_next;

        // The last byte of a file always returns the parser to its start state.
        if (go && beat.last_byte)
        begin
            pos_next        = 40'd0;
            shift_next      = 32'd0;
            fill_next       = 2'd0;
            phase_next      = PH_RIFF;
            riff_next       = 32'd0;
            area_end_next   = 33'd0;
            kind_next       = 32'd0;
            skip_next       = 33'd0;
            fmt_seen_next   = 1'b0;
            fmt_start_next  = 32'd0;
            data_seen_next  = 1'b0;
            data_start_next = 32'd0;
            data_len_next   = 32'd0;
            finished_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg    <= MIN_FORMAT_LENGTH_RESET;
            pos_reg        <= 40'd0;
            shift_reg      <= 32'd0;
            fill_reg       <= 2'd0;
            phase_reg      <= PH_RIFF;
            riff_reg       <= 32'd0;
            area_end_reg   <= 33'd0;
            kind_reg       <= 32'd0;
            skip_reg       <= 33'd0;
            fmt_seen_reg   <= 1'b0;
            fmt_start_reg  <= 32'd0;
            data_seen_reg  <= 1'b0;
            data_start_reg <= 32'd0;
            data_len_reg   <= 32'd0;
            finished_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                min_len_reg <= cfg_write_data;
            end
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            fill_reg       <= fill_next;
            phase_reg      <= phase_next;
            riff_reg       <= riff_next;
            area_end_reg   <= area_end_next;
            kind_reg       <= kind_next;
            skip_reg       <= skip_next;
            fmt_seen_reg   <= fmt_seen_next;
            fmt_start_reg  <= fmt_start_next;
            data_seen_reg  <= data_seen_next;
            data_start_reg <= data_start_next;
            data_len_reg   <= data_len_next;
            finished_reg   <= finished_next;
        end
    end

    `RWCP_ASSERT_NEXT(a_last_restarts, go && beat.last_byte, !finished_reg && pos_reg == 40'd0, "last byte did not restart the parser")
    `RWCP_ASSERT_NOW(a_one_result, emit.valid, go && !finished_reg, "result from a finished or idle parser")
    `RWCP_ASSERT_NOW(a_skip_live, phase_reg == PH_SKIP && !finished_reg, skip_reg != 33'd0, "skip phase with nothing left to skip")
    `RWCP_ASSERT_NOW(a_header_fail_empty, emit.valid && (emit.result.status == ST_NOT_WAVE || emit.result.status == ST_NOT_RIFF), emit.result.format_offset == 32'd0 && emit.result.data_offset == 32'd0 && emit.result.data_size == 32'd0, "header failure reports recorded chunks")

endmodule

`default_nettype wire

// ===== sv/rwcp_out_stage.sv =====
// Result register that holds one result beat until the receiver takes it.
`default_nettype none

module rwcp_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rwcp_pkg::emit_t emit,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output rwcp_pkg::result_t    result
);
    import rwcp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The parser only emits when this register is free or draining.
    assign valid_next = emit.valid ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg <= emit.result;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ===== sv/riff_wave_chunk_parser.sv =====
// Top level of the RIFF/WAVE chunk parser: input register, parser and result register.
//
// Usage. A file enters one byte per beat on the input channel (in_valid/in_ready,
// file_byte, last_byte); last_byte marks the final byte of each file. For each file
// the block gives at most one result beat on the output channel (out_valid/out_ready,
// status, format_offset, data_offset, data_size): as soon as both the fmt and data
// chunks are located, on a header or fmt-length error, when the chunk area runs out,
// or at the last byte if nothing was reported earlier. Bytes after a result are
// dropped until last_byte, which returns the parser to its start-of-file state.
// An accepted byte is loaded into the input register; when the parser takes it, any result
// it causes is loaded into the result register, and a stall on out_ready can hold the take.
// Throughput: one byte per cycle while no result waits for the receiver.
// When the receiver stalls with a result pending, the input register still takes one more
// byte if it is empty; in_ready then stays low until the result is taken.
// Reset clears both registers' valid flags and the parse state; min_format_length
// returns to 14. cfg_write_en writes it at once and should be used only while idle.
`default_nettype none

module riff_wave_chunk_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [15:0] cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  file_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      format_offset,
    output logic [31:0]      data_offset,
    output logic [31:0]      data_size
);
    import rwcp_pkg::*;

    beat_t   in_beat;
    beat_t   held_beat;
    logic    held_valid;
    logic    take;
    emit_t   emit;
    result_t result;

    assign in_beat.file_byte = file_byte;
    assign in_beat.last_byte = last_byte;

    // A held byte is processed whenever the result register can accept a new result,
    // which covers bytes that produce none as well.
    assign take = held_valid && (!out_valid || out_ready);

    rwcp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .take       (take),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    rwcp_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .go             (take),
        .beat           (held_beat),
        .emit           (emit)
    );

    rwcp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign status        = result.status;
    assign format_offset = result.format_offset;
    assign data_offset   = result.data_offset;
    assign data_size     = result.data_size;

endmodule

`default_nettype wire

// ===== test/tb_riff_wave_chunk_parser.sv =====
// Testbench for the RIFF/WAVE chunk parser: directed and random files checked against a local model.
module tb_riff_wave_chunk_parser;

    import rwcp_pkg::*;

    // A chunk kind that the parser never records, used as filler between chunks.
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;

    // Chance, out of a hundred, that either side idles on a given cycle.
    localparam int unsigned IDLE_PERCENT = 31;

    // Cycles allowed after the last result for bytes still inside the block.
    localparam int unsigned SETTLE_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  file_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] format_offset;
    logic [31:0] data_offset;
    logic [31:0] data_size;

    riff_wave_chunk_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .file_byte      (file_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .format_offset  (format_offset),
        .data_offset    (data_offset),
        .data_size      (data_size)
    );

    always #5 clk = ~clk;

    // Reports that the parser owes us, oldest first.
    result_t pending_reports[$];

    // The file currently being assembled for sending.
    logic [7:0] file_bytes[$];

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;

    // ------------------------------------------------------------------
    // Local model of the parser. It mirrors the block's state and is
    // advanced once for every byte beat that the block accepts.
    // ------------------------------------------------------------------
    logic [15:0] min_fmt_len = MIN_FORMAT_LENGTH_RESET;
    logic [39:0] seen_pos;
    logic [31:0] word_acc;
    logic [1:0]  word_bytes;
    phase_t      walk_phase;
    logic [31:0] riff_word;
    logic [32:0] area_end;
    logic [31:0] kind_word;
    logic [32:0] body_left;
    logic        fmt_found;
    logic [31:0] fmt_body;
    logic        data_found;
    logic [31:0] data_body;
    logic [31:0] data_len;
    logic        report_sent;

    // Start-of-file state; the minimum fmt length survives it.
    function automatic void restart_file();
        seen_pos    = '0;
        word_acc    = '0;
        word_bytes  = '0;
        walk_phase  = PH_RIFF;
        riff_word   = '0;
        area_end    = '0;
        kind_word   = '0;
        body_left   = '0;
        fmt_found   = 1'b0;
        fmt_body    = '0;
        data_found  = 1'b0;
        data_body   = '0;
        data_len    = '0;
        report_sent = 1'b0;
    endfunction

    // Queue the one report of this file; whatever was recorded so far goes with it.
    function automatic void latch_report(status_t code);
        result_t r;
        r.status        = code;
        r.format_offset = fmt_body;
        r.data_offset   = data_body;
        r.data_size     = data_len;
        pending_reports.push_back(r);
        report_sent = 1'b1;
    endfunction

    // Move on to the next chunk header, or give up once the chunk area is spent.
    function automatic void advance_chunk();
        if (seen_pos >= {7'd0, area_end})
            latch_report(ST_NOT_FOUND);
        else
            walk_phase = PH_KIND;
    endfunction

    function automatic void take_file_word(logic [31:0] w);
        logic [31:0] here;
        here = seen_pos[31:0];
        case (walk_phase)
            PH_RIFF:
            begin
                riff_word  = w;
                walk_phase = PH_LEN;
            end
            PH_LEN:
            begin
                area_end   = 33'd8 + {1'b0, w};
                walk_phase = PH_FORM;
            end
            PH_FORM:
            begin
                // The form type is judged before the tag.
                if (w != TAG_WAVE)
                    latch_report(ST_NOT_WAVE);
                else if (riff_word != TAG_RIFF)
                    latch_report(ST_NOT_RIFF);
                else
                    advance_chunk();
            end
            PH_KIND:
            begin
                kind_word  = w;
                walk_phase = PH_CLEN;
            end
            PH_CLEN:
            begin
                if (kind_word == TAG_FMT && !fmt_found)
                begin
                    if (w < {16'd0, min_fmt_len})
                    begin
                        latch_report(ST_FMT_SHORT);
                        return;
                    end
                    fmt_found = 1'b1;
                    fmt_body  = here;
                    if (data_found && data_len != 32'd0)
                    begin
                        latch_report(ST_OK);
                        return;
                    end
                end
                else if (kind_word == TAG_DATA && !(data_found && data_len != 32'd0))
                begin
                    // An empty data chunk may be replaced by a later one.
                    data_found = 1'b1;
                    data_body  = here;
                    data_len   = w;
                    if (fmt_found)
                    begin
                        latch_report(ST_OK);
                        return;
                    end
                end
                body_left = ({1'b0, w} + 33'd1) & ~33'd1;
                if (body_left == 33'd0)
                    advance_chunk();
                else
                    walk_phase = PH_SKIP;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void follow_byte(logic [7:0] b, logic last);
        if (!report_sent)
        begin
            word_acc = {b, word_acc[31:8]};
            if (seen_pos < POS_MAX)
                seen_pos = seen_pos + 40'd1;
            if (walk_phase == PH_SKIP)
            begin
                if (body_left != 33'd0)
                    body_left = body_left - 33'd1;
                if (body_left == 33'd0)
                    advance_chunk();
            end
            else
            begin
                word_bytes = word_bytes + 2'd1;
                if (word_bytes == 2'd0)
                    take_file_word(word_acc);
            end
            // A file that ends before anything was reported reports not found.
            if (last && !report_sent)
                latch_report(ST_NOT_FOUND);
        end
        if (last)
            restart_file();
    endfunction

    // ------------------------------------------------------------------
    // Monitor and checker. Both sample at the rising edge, so they see the
    // same values as the block does at that edge.
    // ------------------------------------------------------------------
    task automatic log_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        $display("MISMATCH at %0t: %s got %h, expected %h", $realtime, what, seen, wanted);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            follow_byte(file_byte, last_byte);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
                log_mismatch("report with none outstanding, status", 32'(status), 32'd0);
            else
            begin
                result_t want;
                want = pending_reports.pop_front();
                if (status !== want.status)
                    log_mismatch("status", 32'(status), 32'(want.status));
                if (format_offset !== want.format_offset)
                    log_mismatch("format_offset", format_offset, want.format_offset);
                if (data_offset !== want.data_offset)
                    log_mismatch("data_offset", data_offset, want.data_offset);
                if (data_size !== want.data_size)
                    log_mismatch("data_size", data_size, want.data_size);
            end
        end
    end

    // The receiver stalls at random while receiver_idles is set.
    always @(posedge clk)
        out_ready <= !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);

    // ------------------------------------------------------------------
    // Sending side.
    // ------------------------------------------------------------------

    // Offer one byte beat and hold it until the block takes it. Valid is only
    // lowered while idling, so it never drops and rises within one step.
    task automatic send_beat(logic [7:0] b, logic last);
        while (sender_idles && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        file_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every owed report has come back, then wait out SETTLE_CYCLES
    // for bytes that cause no report but are still in flight.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The register is only written with the block idle.
    task automatic set_min_format(logic [15:0] value);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        min_fmt_len = value;
        @(posedge clk);
    endtask

    // Send the assembled file with the last flag on its final byte.
    task automatic stream_file(bit settle);
        int unsigned count;
        count = file_bytes.size();
        for (int unsigned i = 0; i < count; i++)
            send_beat(file_bytes[i], i == count - 1);
        bytes_sent += count;
        file_bytes.delete();
        if (settle)
            wait_drained();
    endtask

    // ------------------------------------------------------------------
    // File assembly. Words go out little-endian, as in a real file.
    // ------------------------------------------------------------------
    function automatic void add_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_filler(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_header(logic [31:0] tag, logic [31:0] riff_len,
                                       logic [31:0] form);
        add_word(tag);
        add_word(riff_len);
        add_word(form);
    endfunction

    // A whole chunk with its body padded to an even size; small lengths only.
    function automatic void add_chunk(logic [31:0] kind, logic [31:0] len);
        add_word(kind);
        add_word(len);
        add_filler((len + 32'd1) & ~32'd1);
    endfunction

    // Mostly well-formed files with random chunk order and lengths, the rest
    // damaged headers, odd area lengths, truncations and plain noise.
    function automatic void build_random_file();
        int unsigned r;
        int unsigned n_chunks;
        int unsigned keep;
        logic [31:0] kinds[4];
        logic [31:0] lens[4];
        logic [31:0] total;
        logic [31:0] riff_len;
        logic [31:0] tag;
        logic [31:0] form;
        if ($urandom_range(99) < 10)
        begin
            add_filler($urandom_range(1, 16));
            return;
        end
        n_chunks = $urandom_range(0, 4);
        total = 32'd4;
        for (int i = 0; i < 4; i++)
        begin
            r = $urandom_range(9);
            if (r < 3)
                kinds[i] = TAG_FMT;
            else if (r < 6)
                kinds[i] = TAG_DATA;
            else if (r == 6)
                kinds[i] = (r[0] ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(31));
            else
                kinds[i] = $urandom;
            r = $urandom_range(99);
            if (r < 10)
                lens[i] = 32'd0;
            else if (r < 94)
                lens[i] = $urandom_range(1, 24);
            else
                lens[i] = $urandom;
            if (i < n_chunks)
                total = total + 32'd8 + ((lens[i] + 32'd1) & ~32'd1);
        end
        r = $urandom_range(99);
        if (r < 70)
            riff_len = total;
        else if (r < 85)
            riff_len = total - $urandom_range(0, 12);
        else if (r < 95)
            riff_len = $urandom_range(0, 4);
        else
            riff_len = 32'hFFFF_FFFF;
        tag  = TAG_RIFF;
        form = TAG_WAVE;
        r = $urandom_range(99);
        if (r < 8)
            tag = tag ^ (32'd1 << $urandom_range(31));
        if (r >= 4 && r < 12)
            form = form ^ (32'd1 << $urandom_range(31));
        add_header(tag, riff_len, form);
        for (int unsigned i = 0; i < n_chunks; i++)
        begin
            add_word(kinds[i]);
            add_word(lens[i]);
            // A huge body cannot be sent, so such a file is cut short.
            if (lens[i] > 32'd64)
            begin
                add_filler($urandom_range(0, 6));
                break;
            end
            add_filler((lens[i] + 32'd1) & ~32'd1);
        end
        if ($urandom_range(99) < 20)
            add_filler($urandom_range(1, 4));
        if ($urandom_range(99) < 10)
        begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep)
                void'(file_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Broken headers and too short RIFF lengths; the bytes after the report are dropped.
    task automatic test_header_checks();
        // Both tag and form wrong: the form is reported.
        add_header(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_filler(3);
        stream_file(1'b0);
        add_header(TAG_RIFF ^ 32'h0100_0000, 32'd100, TAG_WAVE ^ 32'd1);
        stream_file(1'b0);
        // Form right, tag wrong.
        add_header(32'hFFFF_FFFF, 32'd0, TAG_WAVE);
        add_filler(5);
        stream_file(1'b0);
        // A RIFF length too short for any chunk area.
        add_header(TAG_RIFF, 32'd4, TAG_WAVE);
        add_filler(5);
        stream_file(1'b0);
        add_header(TAG_RIFF, 32'd0, TAG_WAVE);
        stream_file(1'b1);
    endtask

    // Chunk walking: order, padding, retaking of empty data, ignored fmt
    // repeats and the end of the chunk area. The sender waits for each report.
    task automatic test_chunk_walk();
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_FMT, 32'd16);
        add_chunk(TAG_DATA, 32'd8);
        stream_file(1'b1);
        // Data ahead of fmt, with odd lengths that need padding.
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd5);
        add_chunk(TAG_LIST, 32'd3);
        add_chunk(TAG_FMT, 32'd18);
        stream_file(1'b1);
        // An empty data chunk gives way to the next one.
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd0);
        add_chunk(TAG_DATA, 32'd6);
        add_chunk(TAG_FMT, 32'd16);
        stream_file(1'b1);
        // A second data chunk after a non-empty one is skipped.
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd4);
        add_chunk(TAG_DATA, 32'd10);
        add_chunk(TAG_FMT, 32'd14);
        stream_file(1'b1);
        // A later, too short fmt chunk is ignored, as is an empty chunk.
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_FMT, 32'd16);
        add_chunk(TAG_FMT, 32'd2);
        add_chunk(TAG_LIST, 32'd0);
        add_chunk(TAG_DATA, 32'd2);
        stream_file(1'b1);
        // A header starting inside the area is read whole although it runs past it.
        add_header(TAG_RIFF, 32'd6, TAG_WAVE);
        add_chunk(TAG_LIST, 32'd0);
        add_filler(3);
        stream_file(1'b1);
        add_header(TAG_RIFF, 32'd14, TAG_WAVE);
        add_chunk(TAG_FMT, 32'd16);
        add_chunk(TAG_DATA, 32'd2);
        stream_file(1'b1);
        // The area ends exactly after one data chunk.
        add_header(TAG_RIFF, 32'd18, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd5);
        add_filler(4);
        stream_file(1'b1);
    endtask

    // Files that end before anything is reported.
    task automatic test_early_end();
        add_filler(1);
        stream_file(1'b0);
        add_word(TAG_RIFF);
        add_filler(2);
        stream_file(1'b0);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_word(TAG_FMT);
        add_word(32'd16);
        add_filler(5);
        stream_file(1'b0);
        // A data chunk far too long to skip, cut short by the last flag.
        add_header(TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE);
        add_word(TAG_DATA);
        add_word(32'h8000_0001);
        add_filler(7);
        stream_file(1'b1);
    endtask

    // All-ones and all-zero length words.
    task automatic test_extreme_words();
        add_header(TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE);
        add_chunk(TAG_FMT, 32'd16);
        add_word(TAG_DATA);
        add_word(32'hFFFF_FFFF);
        add_filler(2);
        stream_file(1'b0);
        // An empty data chunk still completes the pair once fmt is known.
        add_header(TAG_RIFF, 32'hFFFF_FFFE, TAG_WAVE);
        add_chunk(TAG_LIST, 32'd1);
        add_chunk(TAG_FMT, 32'd17);
        add_word(TAG_DATA);
        add_word(32'd0);
        stream_file(1'b1);
    endtask

    // The minimum fmt length at its reset value, both extremes and a random one.
    task automatic test_format_length();
        logic [15:0] limit;
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_FMT, 32'd13);
        stream_file(1'b0);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_FMT, 32'd14);
        add_chunk(TAG_DATA, 32'd1);
        stream_file(1'b0);

        set_min_format(16'd0);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_FMT, 32'd0);
        add_chunk(TAG_DATA, 32'd2);
        stream_file(1'b0);

        set_min_format(16'hFFFF);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd4);
        add_word(TAG_FMT);
        add_word(32'd65534);
        add_filler(2);
        stream_file(1'b0);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd4);
        add_word(TAG_FMT);
        add_word(32'd65535);
        add_filler(2);
        stream_file(1'b0);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd4);
        add_word(TAG_FMT);
        add_word(32'hFFFF_FFFF);
        stream_file(1'b0);

        // Either side of a random minimum.
        limit = 16'($urandom_range(1, 200));
        set_min_format(limit);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd2);
        add_word(TAG_FMT);
        add_word({16'd0, limit - 16'd1});
        add_filler(3);
        stream_file(1'b0);
        add_header(TAG_RIFF, 32'd1000, TAG_WAVE);
        add_chunk(TAG_DATA, 32'd2);
        add_word(TAG_FMT);
        add_word({16'd0, limit});
        stream_file(1'b0);

        set_min_format(MIN_FORMAT_LENGTH_RESET);
    endtask

    // Random files back to back with neither side ever idling.
    task automatic test_back_to_back();
        int unsigned goal;
        wait_drained();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        goal = bytes_sent + 200;
        while (bytes_sent < goal)
        begin
            build_random_file();
            stream_file(1'b0);
        end
        wait_drained();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Random files in batches, each under its own minimum fmt length. Now and
    // then the sender waits for every report before going on.
    task automatic run_random_batch(logic [15:0] limit, int unsigned byte_count);
        int unsigned goal;
        set_min_format(limit);
        goal = bytes_sent + byte_count;
        while (bytes_sent < goal)
        begin
            build_random_file();
            stream_file($urandom_range(99) < 5);
        end
    endtask

    task automatic test_random_files();
        run_random_batch(MIN_FORMAT_LENGTH_RESET, 300);
        run_random_batch(16'($urandom_range(0, 30)), 200);
        run_random_batch(16'd0, 100);
        run_random_batch(16'hFFFF, 100);
        run_random_batch(MIN_FORMAT_LENGTH_RESET, 50);
    endtask

    initial
    begin
        restart_file();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_checks();
        test_chunk_walk();
        test_early_end();
        test_extreme_words();
        test_format_length();
        test_back_to_back();
        test_random_files();

        wait_drained();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: a run that hangs, or a report that never arrives, ends here.
    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
